// ===== hdl/lfr_pkg.sv =====
// shared constants and types for the lru frame replacer
package lfr_pkg;

    // fixed field widths
    localparam int FID_W     = 6;
    localparam int MODE_W    = 2;
    localparam int CNT_OUT_W = 7;

    // default number of frames in the table
    localparam int DEF_NUM_FRAMES = 64;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;

    // update request for the order array
    typedef struct packed {
        logic             pop;
        logic             pin;
        logic             push;
        logic [FID_W-1:0] fid;
    } lfr_order_op_t;

    // status of the order array
    typedef struct packed {
        logic [FID_W-1:0] head;
        logic             empty;
        logic             full;
    } lfr_order_stat_t;

    // update request for the tracked bits
    typedef struct packed {
        logic             set_en;
        logic [FID_W-1:0] set_id;
        logic             clr_en;
        logic [FID_W-1:0] clr_id;
    } lfr_track_upd_t;

endpackage

// ===== hdl/lru_frame_replacer.sv =====
// lru frame replacer top level: input register, decode, result register
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------------
//  input    | in_valid / in_stall         | mode, frame_num
//  output   | out_valid / out_stall       | victim_found, victim_frame, tracked_count,
//           |                             | id_rejected
//
// one item per cycle while out_stall is low; the result register takes each item from the input register
// the shift array compare and compaction are combinational between the
// input register and the result register
// reset clears the tracked bits, the entry count and both valid flags
// a stalled result holds; one more item waits in the input register, then
// in_stall rises
module lru_frame_replacer
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [FID_W-1:0]     frame_num,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 victim_found,
    output logic [FID_W-1:0]     victim_frame,
    output logic [CNT_OUT_W-1:0] tracked_count,
    output logic                 id_rejected
);

    localparam int CntW = $clog2(NUM_FRAMES + 1);

    logic                 in_vld_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [FID_W-1:0]     fid_reg;
    logic                 out_vld_reg;
    logic                 found_reg;
    logic [FID_W-1:0]     vframe_reg;
    logic [CNT_OUT_W-1:0] count_out_reg;
    logic                 rejected_reg;

    logic                 advance;
    logic                 proc;
    logic                 in_range;
    logic                 hit;
    logic                 do_victim;
    logic                 do_pin;
    logic                 do_push;
    logic                 is_frame_op;
    logic [CntW-1:0]      count;
    logic [CntW-1:0]      count_after;
    logic [CntW+CNT_OUT_W-1:0] count_wide;
    lfr_order_op_t        order_op;
    lfr_order_stat_t      order_stat;
    lfr_track_upd_t       track_upd;

    // handshake
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign proc     = in_vld_reg && advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            fid_reg  <= frame_num;
        end
    end

    // operation decode
    assign in_range = (32'(fid_reg) < NUM_FRAMES);

    always_comb
    begin
        do_victim   = 1'b0;
        do_pin      = 1'b0;
        do_push     = 1'b0;
        is_frame_op = 1'b0;
        unique case (mode_reg)
            MODE_VICTIM:
            begin
                do_victim = !order_stat.empty;
            end
            MODE_PIN:
            begin
                is_frame_op = 1'b1;
                do_pin      = in_range && hit;
            end
            MODE_UNPIN:
            begin
                is_frame_op = 1'b1;
                do_push     = in_range && !hit && !order_stat.full;
            end
            default:
            begin
                do_victim = 1'b0;
            end
        endcase
    end

    assign order_op.pop  = do_victim;
    assign order_op.pin  = do_pin;
    assign order_op.push = do_push;
    assign order_op.fid  = fid_reg;

    assign track_upd.set_en = proc && do_push;
    assign track_upd.set_id = fid_reg;
    assign track_upd.clr_en = proc && (do_pin || do_victim);
    assign track_upd.clr_id = do_victim ? order_stat.head : fid_reg;

    lfr_order #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_order (
        .clk   (clk),
        .rst_n (rst_n),
        .op_en (proc),
        .op    (order_op),
        .stat  (order_stat),
        .count (count)
    );

    lfr_track #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (track_upd),
        .query_id (fid_reg),
        .hit      (hit)
    );

    // count after this item
    always_comb
    begin
        count_after = count;
        if (do_victim || do_pin)
        begin
            count_after = count - CntW'(1);
        end
        else if (do_push)
        begin
            count_after = count + CntW'(1);
        end
    end

    assign count_wide = {{CNT_OUT_W{1'b0}}, count_after};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            found_reg     <= do_victim;
            vframe_reg    <= do_victim ? order_stat.head : '0;
            count_out_reg <= count_wide[CNT_OUT_W-1:0];
            rejected_reg  <= is_frame_op && !in_range;
        end
    end

    assign out_valid     = out_vld_reg;
    assign victim_found  = found_reg;
    assign victim_frame  = vframe_reg;
    assign tracked_count = count_out_reg;
    assign id_rejected   = rejected_reg;

endmodule

// ===== hdl/lfr_track.sv =====
// one tracked bit per frame with lookup of a frame number
module lfr_track
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lfr_track_upd_t   upd,
    input  logic [FID_W-1:0] query_id,
    output logic             hit
);

    logic [NUM_FRAMES-1:0] tracked_reg;
    logic [NUM_FRAMES-1:0] tracked_next;
    logic [NUM_FRAMES-1:0] query_sel;
    logic [NUM_FRAMES-1:0] set_sel;
    logic [NUM_FRAMES-1:0] clr_sel;

    // decode the frame numbers into one-hot selects
    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            query_sel[i] = (32'(query_id) == i);
            set_sel[i]   = upd.set_en && (32'(upd.set_id) == i);
            clr_sel[i]   = upd.clr_en && (32'(upd.clr_id) == i);
        end
    end

    assign hit          = |(tracked_reg & query_sel);
    assign tracked_next = (tracked_reg & ~clr_sel) | set_sel;

    // tracked bits, all cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg <= '0;
        end
        else
        begin
            tracked_reg <= tracked_next;
        end
    end

endmodule

// ===== hdl/lfr_order.sv =====
// ordered shift array of tracked frames, oldest at position zero
module lfr_order
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES,
    localparam int CntW = $clog2(NUM_FRAMES + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_en,
    input  lfr_order_op_t   op,
    output lfr_order_stat_t stat,
    output logic [CntW-1:0] count
);

    logic [FID_W-1:0]      order_reg  [NUM_FRAMES];
    logic [FID_W-1:0]      order_next [NUM_FRAMES];
    logic [FID_W-1:0]      above      [NUM_FRAMES];
    logic [CntW-1:0]       count_reg;
    logic [CntW-1:0]       count_next;
    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] shift_at;
    logic                  remove;

    assign remove = op.pop || op.pin;

    // parallel compare against the live entries and prefix of the hit position
    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            match[i] = op.pin && (order_reg[i] == op.fid) && (CntW'(i) < count_reg);
        end
        shift_at[0] = op.pop || match[0];
        for (int i = 1; i < NUM_FRAMES; i++)
        begin
            shift_at[i] = shift_at[i-1] || match[i];
        end
    end

    // per position: close the gap from above or take the pushed frame
    for (genvar g = 0; g < NUM_FRAMES; g++)
    begin : g_pos
        if (g < NUM_FRAMES - 1)
        begin : g_mid
            assign above[g] = order_reg[g+1];
        end
        else
        begin : g_top
            assign above[g] = order_reg[g];
        end

        always_comb
        begin
            order_next[g] = order_reg[g];
            if (remove && shift_at[g])
            begin
                order_next[g] = above[g];
            end
            else if (op.push && (CntW'(g) == count_reg))
            begin
                order_next[g] = op.fid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (op_en)
            begin
                order_reg[g] <= order_next[g];
            end
        end
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (remove)
        begin
            count_next = count_reg - CntW'(1);
        end
        else if (op.push)
        begin
            count_next = count_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (op_en)
        begin
            count_reg <= count_next;
        end
    end

    assign stat.head  = order_reg[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CntW'(NUM_FRAMES));
    assign count      = count_reg;

endmodule
